### rtl/crot_pkg.sv
// Shared types, constants and register indexes for the crossing route occupancy tracker.
`timescale 1ns / 1ps
package crot_pkg;

  localparam int NUM_ROUTES_DEF         = 4;
  localparam int SWITCHES_PER_ROUTE_DEF = 4;
  localparam int MS_PER_S               = 1000;
  localparam int MASK_BITS              = 16;

  localparam logic [3:0]  ENABLE_RST   = 4'hF;
  localparam logic [7:0]  TIMEOUT_RST  = 8'd30;
  localparam logic [15:0] DEBOUNCE_RST = 16'd500;
  localparam logic [15:0] REACT_RST    = 16'd5000;
  localparam logic [15:0] SINCE_MAX    = 16'hFFFF;

  localparam logic [2:0] REG_ROUTE_ENABLE = 3'd0;
  localparam logic [2:0] REG_TIMEOUT      = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE     = 3'd2;
  localparam logic [2:0] REG_REACT        = 3'd3;
  localparam logic [2:0] REG_SW_CHECK     = 3'd4;
  localparam logic [2:0] REG_SW_POLARITY  = 3'd5;

  typedef enum logic [2:0] {
    LOC_EMPTY   = 3'd0,
    LOC_PRE     = 3'd1,
    LOC_ISL_IN  = 3'd2,
    LOC_ISL     = 3'd3,
    LOC_POST_IN = 3'd4,
    LOC_POST    = 3'd5
  } loc_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_LTR  = 2'd1,
    DIR_RTL  = 2'd2
  } dir_t;

  typedef struct packed {
    loc_t        stage;
    dir_t        dir;
    logic [17:0] timer;
    logic        running;
    logic [15:0] hold;
    logic [15:0] since;
  } route_t;

  typedef struct packed {
    logic [15:0] debounce;
    logic [15:0] react;
    logic [15:0] chk;
    logic [15:0] pol;
    logic [17:0] timer_load;
  } unit_cfg_t;

  typedef struct packed {
    logic       lo;
    logic       li;
    logic       ri;
    logic       ro;
    logic [3:0] sw;
  } sense_t;

endpackage

### rtl/crot_ifs.sv
// Valid/ready channel interfaces for tracker items and results.
`timescale 1ns / 1ps
interface crot_item_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [1:0] route_index;
  logic       left_outer;
  logic       left_island;
  logic       right_island;
  logic       right_outer;
  logic [3:0] switch_values;

  modport source (output valid, opcode, route_index, left_outer, left_island, right_island,
                  right_outer, switch_values, input ready);
  modport sink (input valid, opcode, route_index, left_outer, left_island, right_island,
                right_outer, switch_values, output ready);
endinterface

interface crot_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] location;
  logic [1:0] travel_direction;
  logic       flash_active;
  logic       lower_arms_pulse;
  logic       raise_arms_pulse;
  logic [3:0] timeout_mask;

  modport source (output valid, location, travel_direction, flash_active, lower_arms_pulse,
                  raise_arms_pulse, timeout_mask, input ready);
  modport sink (input valid, location, travel_direction, flash_active, lower_arms_pulse,
                raise_arms_pulse, timeout_mask, output ready);
endinterface

### rtl/crossing_route_occupancy_tracker.sv
// Top level: sequencer, route state, configuration and result register of the tracker.
//
// Items arrive on the item channel: a millisecond tick (opcode 0) or a sensor
// sample for one route (opcode 1). Each transaction yields one result
// transaction with the addressed route's stage and direction, the flash state,
// arm pulses and the mask of routes cleared by timeout on a tick.
// One shared route unit is stepped by a small sequencer. A tick visits every
// route in turn and a sample updates its route (an ignored sample none); then
// a scan over every route forms the flash state and picks up the reported
// route. Ready returns together with result valid, so a new item is taken
// only once the last one has reached the result register.
// The result register holds one finished result; while the receiver stalls a
// further item may be accepted and worked, and it then waits for the register.
// Configuration writes take effect at once and are to be made while idle; the block does not enforce it.
// Reset (synchronous, rst high) empties all routes, stops all timers, clears
// holds, saturates the time since entry and loads the register defaults.
`timescale 1ns / 1ps
module crossing_route_occupancy_tracker #(
  parameter int NUM_ROUTES         = crot_pkg::NUM_ROUTES_DEF,
  parameter int SWITCHES_PER_ROUTE = crot_pkg::SWITCHES_PER_ROUTE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_wdata,
  crot_item_if.sink     item,
  crot_result_if.source result
);
  import crot_pkg::*;

  localparam int RW = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_TICK   = 5'b00010,
    ST_SAMPLE = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  logic [3:0]  en_mask;
  logic [7:0]  timeout_s;
  logic [15:0] debounce;
  logic [15:0] react;
  logic [15:0] sw_chk;
  logic [15:0] sw_pol;

  state_t      state;
  logic [RW-1:0] rt;
  logic        op_q;
  logic [1:0]  idx_q;
  sense_t      sense_q;
  logic [3:0]  tmask;
  logic        want;
  loc_t        loc_q;
  dir_t        dir_q;
  logic        flash_state;

  logic        ov;
  logic [2:0]  o_loc;
  logic [1:0]  o_dir;
  logic        o_flash;
  logic        o_lower;
  logic        o_raise;
  logic [3:0]  o_tmask;

  route_t      routes [NUM_ROUTES];
  route_t      unit_nxt;
  logic        unit_expired;
  unit_cfg_t   ucfg;

  logic item_acc;
  logic sample_hit;
  logic last;
  logic idx_match;
  logic out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      en_mask   <= ENABLE_RST;
      timeout_s <= TIMEOUT_RST;
      debounce  <= DEBOUNCE_RST;
      react     <= REACT_RST;
      sw_chk    <= '0;
      sw_pol    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROUTE_ENABLE: en_mask   <= cfg_wdata[3:0];
        REG_TIMEOUT:      timeout_s <= cfg_wdata[7:0];
        REG_DEBOUNCE:     debounce  <= cfg_wdata;
        REG_REACT:        react     <= cfg_wdata;
        REG_SW_CHECK:     sw_chk    <= cfg_wdata;
        REG_SW_POLARITY:  sw_pol    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ucfg.debounce   = debounce;
  assign ucfg.react      = react;
  assign ucfg.chk        = sw_chk;
  assign ucfg.pol        = sw_pol;
  assign ucfg.timer_load = 18'(timeout_s) * 18'(MS_PER_S);

  crot_route_unit #(
    .NUM_ROUTES         (NUM_ROUTES),
    .SWITCHES_PER_ROUTE (SWITCHES_PER_ROUTE)
  ) u_unit (
    .sample  (op_q),
    .route   (rt),
    .cfg     (ucfg),
    .sense   (sense_q),
    .cur     (routes[rt]),
    .nxt     (unit_nxt),
    .expired (unit_expired)
  );

  assign item.ready = (state == ST_IDLE) && !rst;
  assign item_acc   = item.valid && item.ready;
  assign sample_hit = item.opcode && (32'(item.route_index) < NUM_ROUTES)
                      && en_mask[item.route_index];
  assign last       = (rt == RW'(NUM_ROUTES - 1));
  assign idx_match  = (32'(rt) == 32'(idx_q));
  assign out_free   = !ov || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rt          <= '0;
      tmask       <= '0;
      want        <= 1'b0;
      flash_state <= 1'b0;
      for (int r = 0; r < NUM_ROUTES; r++) begin
        routes[r].stage   <= LOC_EMPTY;
        routes[r].dir     <= DIR_NONE;
        routes[r].timer   <= '0;
        routes[r].running <= 1'b0;
        routes[r].hold    <= '0;
        routes[r].since   <= SINCE_MAX;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_acc) begin
            op_q    <= item.opcode;
            idx_q   <= item.route_index;
            sense_q <= '{lo: item.left_outer, li: item.left_island, ri: item.right_island,
                         ro: item.right_outer, sw: item.switch_values};
            tmask   <= '0;
            want    <= 1'b0;
            loc_q   <= LOC_EMPTY;
            dir_q   <= DIR_NONE;
            if (!item.opcode) begin
              rt    <= '0;
              state <= ST_TICK;
            end else if (sample_hit) begin
              rt    <= RW'(item.route_index);
              state <= ST_SAMPLE;
            end else begin
              rt    <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_TICK: begin
          routes[rt] <= unit_nxt;
          if (unit_expired && 32'(rt) < 4) begin
            tmask <= tmask | (4'(1) << rt);
          end
          rt <= last ? '0 : rt + RW'(1);
          if (last) begin
            state <= ST_SCAN;
          end
        end
        ST_SAMPLE: begin
          routes[rt] <= unit_nxt;
          rt         <= '0;
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          if (routes[rt].stage == LOC_PRE || routes[rt].stage == LOC_ISL_IN
              || routes[rt].stage == LOC_ISL) begin
            want <= 1'b1;
          end
          if (idx_match) begin
            loc_q <= routes[rt].stage;
            dir_q <= routes[rt].dir;
          end
          rt <= last ? '0 : rt + RW'(1);
          if (last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            flash_state <= want;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      ov <= 1'b1;
    end else if (result.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      o_loc   <= 3'(loc_q);
      o_dir   <= 2'(dir_q);
      o_flash <= want;
      o_lower <= want && !flash_state;
      o_raise <= !want && flash_state;
      o_tmask <= tmask;
    end
  end

  assign result.valid            = ov;
  assign result.location         = o_loc;
  assign result.travel_direction = o_dir;
  assign result.flash_active     = o_flash;
  assign result.lower_arms_pulse = o_lower;
  assign result.raise_arms_pulse = o_raise;
  assign result.timeout_mask     = o_tmask;

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(ov) |-> $past(state == ST_DONE))
    else $error("result loaded outside the done step");

  a_sample_to_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SAMPLE) |=> (state == ST_SCAN && rt == '0))
    else $error("sample update not followed by flash scan");

  a_flash_held: assert property (@(posedge clk) disable iff (rst)
    ov |-> (result.flash_active == flash_state))
    else $error("reported flash differs from flash state");

  a_pulses_excl: assert property (@(posedge clk) disable iff (rst)
    ov |-> !(o_lower && o_raise))
    else $error("lower and raise pulses together");

  a_timeout_no_lower: assert property (@(posedge clk) disable iff (rst)
    (ov && o_tmask != 4'd0) |-> !o_lower)
    else $error("timeout transaction lowered the arms");

endmodule

### rtl/crot_route_unit.sv
// Shared per-route update unit: tick timers, train entry, switch check and stage stepping.
`timescale 1ns / 1ps
module crot_route_unit #(
  parameter int NUM_ROUTES         = crot_pkg::NUM_ROUTES_DEF,
  parameter int SWITCHES_PER_ROUTE = crot_pkg::SWITCHES_PER_ROUTE_DEF,
  localparam int RW = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1
) (
  input  logic                sample,
  input  logic [RW-1:0]       route,
  input  crot_pkg::unit_cfg_t cfg,
  input  crot_pkg::sense_t    sense,
  input  crot_pkg::route_t    cur,
  output crot_pkg::route_t    nxt,
  output logic                expired
);
  import crot_pkg::*;

  logic sw_ok;
  logic near_isl, far_isl, far_outer;

  always_comb begin : switch_check
    int   b;
    logic want_v, have_v;
    sw_ok = 1'b1;
    for (int x = 0; x < SWITCHES_PER_ROUTE; x++) begin
      b      = int'(route) * SWITCHES_PER_ROUTE + x;
      want_v = cfg.pol[b[3:0]];
      have_v = (x < 4) ? sense.sw[2'(x)] : 1'b0;
      if (b < MASK_BITS && cfg.chk[b[3:0]] && (want_v != have_v)) begin
        sw_ok = 1'b0;
      end
    end
  end

  assign near_isl  = (cur.dir == DIR_RTL) ? sense.ri : sense.li;
  assign far_isl   = (cur.dir == DIR_RTL) ? sense.li : sense.ri;
  assign far_outer = (cur.dir == DIR_RTL) ? sense.lo : sense.ro;

  always_comb begin
    nxt     = cur;
    expired = 1'b0;
    if (!sample) begin
      if (cur.since != SINCE_MAX) begin
        nxt.since = cur.since + 16'd1;
      end
      if (cur.hold != 16'd0) begin
        nxt.hold = cur.hold - 16'd1;
      end
      if (cur.running) begin
        if (cur.timer <= 18'd1) begin
          nxt.timer   = '0;
          nxt.running = 1'b0;
          if (cur.stage != LOC_EMPTY) begin
            nxt.stage = LOC_EMPTY;
            nxt.dir   = DIR_NONE;
            nxt.hold  = cfg.react;
            expired   = 1'b1;
          end
        end else begin
          nxt.timer = cur.timer - 18'd1;
        end
      end
    end else if ((sense.lo || sense.ro) && cur.stage == LOC_EMPTY && cur.hold == 16'd0) begin
      if (sw_ok) begin
        nxt.since   = '0;
        nxt.stage   = LOC_PRE;
        nxt.dir     = sense.lo ? DIR_LTR : DIR_RTL;
        nxt.timer   = cfg.timer_load;
        nxt.running = 1'b1;
      end
    end else if ((cur.dir == DIR_LTR || cur.dir == DIR_RTL) && cur.since >= cfg.debounce) begin
      case (cur.stage)
        LOC_PRE: begin
          if (near_isl) begin
            nxt.stage   = LOC_ISL_IN;
            nxt.timer   = cfg.timer_load;
            nxt.running = 1'b1;
          end
        end
        LOC_ISL_IN: begin
          if (far_isl) begin
            nxt.stage   = LOC_ISL;
            nxt.timer   = cfg.timer_load;
            nxt.running = 1'b1;
          end
        end
        LOC_ISL: begin
          if (!far_isl) begin
            nxt.stage   = LOC_POST_IN;
            nxt.timer   = cfg.timer_load;
            nxt.running = 1'b1;
          end
        end
        LOC_POST_IN: begin
          if (far_outer) begin
            nxt.stage   = LOC_POST;
            nxt.timer   = cfg.timer_load;
            nxt.running = 1'b1;
          end
        end
        LOC_POST: begin
          if (!far_outer) begin
            nxt.stage   = LOC_EMPTY;
            nxt.dir     = DIR_NONE;
            nxt.hold    = cfg.react;
            nxt.running = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
